// ===== src/peu_pkg.sv =====
// ----------------------------------------------------------------------------
// peu_pkg
// Types, constants and helpers shared by the particle Euler update pipeline.
// ----------------------------------------------------------------------------
package peu_pkg;

    localparam logic [15:0] AGE_ONE = 16'd16384;

    localparam int DIV_BITS = 32;
    localparam int DIV_LAT  = DIV_BITS + 2;

    localparam logic [1:0] ST_DEAD_BEFORE = 2'd0;
    localparam logic [1:0] ST_DIED_NOW    = 2'd1;
    localparam logic [1:0] ST_ALIVE       = 2'd2;

    localparam logic [2:0] REG_PAUSED          = 3'd0;
    localparam logic [2:0] REG_TIME_STEP       = 3'd1;
    localparam logic [2:0] REG_FORCE_MASK      = 3'd2;
    localparam logic [2:0] REG_FORCE_X_FIRST   = 3'd3;
    localparam logic [2:0] REG_FORCE_Y_FIRST   = 3'd4;
    localparam logic [2:0] REG_FORCE_X_SECOND  = 3'd5;
    localparam logic [2:0] REG_FORCE_Y_SECOND  = 3'd6;

    localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

    typedef struct packed {
        logic [15:0]        age;
        logic [15:0]        aging_rate;
        logic signed [31:0] mass_birth;
        logic signed [31:0] mass_death;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] radius_birth;
        logic signed [31:0] radius_death;
    } in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [15:0]        new_age;
        logic signed [31:0] mass_now;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] radius_now;
    } out_t;

    // per-stage particle record
    typedef struct packed {
        logic [1:0]         status;
        logic [15:0]        new_age;
        logic signed [31:0] mass;
        logic signed [31:0] radius;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
    } pay_t;

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        logic signed [31:0] r;
        if (v > 50'sd2147483647)
            r = SAT_MAX;
        else if (v < -50'sd2147483648)
            r = SAT_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ===== src/peu_div.sv =====
// ----------------------------------------------------------------------------
// peu_div
// Pipelined saturating signed divide: trunc(force * 2^16 / mass), one
// quotient bit per stage, one request per cycle while en[0] is set.
// ----------------------------------------------------------------------------
module peu_div
    import peu_pkg::*;
(
    input  logic                      clk,
    input  logic [DIV_LAT-1:0]        en,
    input  logic signed [31:0]        force_val,
    input  logic signed [31:0]        mass,
    output logic signed [31:0]        quo
);

    typedef struct packed {
        logic neg;
        logic ovf;
        logic f_zero;
    } flag_t;

    logic [31:0] rem_reg  [DIV_BITS+1];
    logic [31:0] dvd_reg  [DIV_BITS+1];
    logic [31:0] q_reg    [DIV_BITS+1];
    logic [31:0] am_reg   [DIV_BITS+1];
    flag_t       flag_reg [DIV_BITS+1];
    logic signed [31:0] res_reg;
    logic signed [31:0] res_next;

    logic [31:0] af_next;
    logic [31:0] am_next;

    assign af_next = force_val[31] ? 32'(-force_val) : force_val;
    assign am_next = mass[31] ? 32'(-mass) : mass;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rem_reg[0]         <= {16'b0, af_next[31:16]};
            dvd_reg[0]         <= {af_next[15:0], 16'b0};
            q_reg[0]           <= '0;
            am_reg[0]          <= am_next;
            flag_reg[0].neg    <= force_val[31] ^ mass[31];
            flag_reg[0].ovf    <= {16'b0, af_next} >= {am_next, 16'b0};
            flag_reg[0].f_zero <= (force_val == '0);
        end
    end

    for (genvar k = 1; k <= DIV_BITS; k++)
    begin : g_step
        logic [32:0] trial;
        logic [32:0] diff;
        logic        ge;

        assign trial = {rem_reg[k-1], dvd_reg[k-1][31]};
        assign diff  = trial - {1'b0, am_reg[k-1]};
        assign ge    = trial >= {1'b0, am_reg[k-1]};

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                rem_reg[k]  <= ge ? diff[31:0] : trial[31:0];
                dvd_reg[k]  <= {dvd_reg[k-1][30:0], 1'b0};
                q_reg[k]    <= {q_reg[k-1][30:0], ge};
                am_reg[k]   <= am_reg[k-1];
                flag_reg[k] <= flag_reg[k-1];
            end
        end
    end

    always_comb
    begin
        if (flag_reg[DIV_BITS].f_zero)
            res_next = '0;
        else if (flag_reg[DIV_BITS].ovf)
            res_next = flag_reg[DIV_BITS].neg ? SAT_MIN : SAT_MAX;
        else if (flag_reg[DIV_BITS].neg)
            res_next = (q_reg[DIV_BITS] > 32'h80000000) ? SAT_MIN
                                                         : 32'(-q_reg[DIV_BITS]);
        else
            res_next = q_reg[DIV_BITS][31] ? SAT_MAX : q_reg[DIV_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (en[DIV_LAT-1])
            res_reg <= res_next;
    end

    assign quo = res_reg;

endmodule

// ===== src/particle_euler_update_top.sv =====
// ----------------------------------------------------------------------------
// particle_euler_update_top
// One Euler time step of a 2D particle record: aging, mass/radius lerp,
// directional forces, velocity and position update, all saturating.
// ----------------------------------------------------------------------------
// Fully pipelined: one particle request accepted per cycle while in_stall is low,
// results in order, DIV_BITS + NUM_FORCES + 9 register stages. The 34-stage
// force/mass divider sets the depth. Each stage moves when its successor is
// empty or moving, so bubbles close up and requests keep entering while a
// result waits at the output. Configuration writes are always ready and take
// effect at once; write them only while idle.
// ----------------------------------------------------------------------------
module particle_euler_update_top
    import peu_pkg::*;
#(
    parameter int NUM_FORCES = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_t         in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_t        out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int S_Q  = 4 + DIV_LAT;
    localparam int S_VM = S_Q + 1 + NUM_FORCES;
    localparam int S_P  = S_VM + 1;
    localparam int NS   = S_P + 1;

    // configuration
    logic                  paused_reg;
    logic [15:0]           time_step_reg;
    logic [NUM_FORCES-1:0] mask_reg;
    logic signed [31:0]    fx_reg [NUM_FORCES];
    logic signed [31:0]    fy_reg [NUM_FORCES];
    logic [15:0]           dt;

    assign cfg_ready = 1'b1;
    assign dt        = paused_reg ? 16'd0 : time_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            paused_reg    <= 1'b0;
            time_step_reg <= '0;
            mask_reg      <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PAUSED:     paused_reg    <= cfg_data[0];
                REG_TIME_STEP:  time_step_reg <= cfg_data[15:0];
                REG_FORCE_MASK: mask_reg      <= cfg_data[NUM_FORCES-1:0];
                default:        ;
            endcase
        end
    end

    for (genvar i = 0; i < NUM_FORCES; i++)
    begin : g_force_cfg
        localparam logic [2:0] IDX_X = (i == 0) ? REG_FORCE_X_FIRST : REG_FORCE_X_SECOND;
        localparam logic [2:0] IDX_Y = (i == 0) ? REG_FORCE_Y_FIRST : REG_FORCE_Y_SECOND;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                fx_reg[i] <= '0;
                fy_reg[i] <= '0;
            end
            else if (cfg_valid)
            begin
                if (cfg_index == IDX_X)
                    fx_reg[i] <= cfg_data;
                if (cfg_index == IDX_Y)
                    fy_reg[i] <= cfg_data;
            end
        end
    end

    // stage flow control
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] en;

    always_comb
    begin
        en[NS-1] = !vld_reg[NS-1] || !out_stall;
        for (int k = NS - 2; k >= 0; k--)
            en[k] = !vld_reg[k] || en[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (en[0])
                vld_reg[0] <= in_valid;
            for (int k = 1; k < NS; k++)
                if (en[k])
                    vld_reg[k] <= vld_reg[k-1];
        end
    end

    assign in_stall  = !en[0];
    assign out_valid = vld_reg[NS-1];

    // stage 0: capture, aging product
    in_t         s0_reg;
    logic [31:0] s0_prod_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_reg      <= in_data;
            s0_prod_reg <= dt * in_data.aging_rate;
        end
    end

    // stage 1: new age, status, lerp differences
    pay_t               s1_reg;
    pay_t               s1_next;
    logic signed [32:0] s1_dm_reg;
    logic signed [32:0] s1_dr_reg;
    logic [22:0]        age_sum;

    always_comb
    begin
        age_sum         = {7'b0, s0_reg.age} + {1'b0, s0_prod_reg[31:10]};
        s1_next.mass    = s0_reg.mass_birth;
        s1_next.radius  = s0_reg.radius_birth;
        s1_next.vel_x   = s0_reg.vel_x;
        s1_next.vel_y   = s0_reg.vel_y;
        s1_next.pos_x   = s0_reg.pos_x;
        s1_next.pos_y   = s0_reg.pos_y;
        if (s0_reg.age > AGE_ONE)
        begin
            s1_next.status  = ST_DEAD_BEFORE;
            s1_next.new_age = s0_reg.age;
        end
        else
        begin
            s1_next.new_age = (age_sum > 23'h00ffff) ? 16'hffff : age_sum[15:0];
            s1_next.status  = (s1_next.new_age > AGE_ONE) ? ST_DIED_NOW : ST_ALIVE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_reg    <= s1_next;
            s1_dm_reg <= 33'(s0_reg.mass_death) - 33'(s0_reg.mass_birth);
            s1_dr_reg <= 33'(s0_reg.radius_death) - 33'(s0_reg.radius_birth);
        end
    end

    // stage 2: lerp products
    pay_t               s2_reg;
    logic signed [49:0] s2_pm_reg;
    logic signed [49:0] s2_pr_reg;
    logic signed [49:0] s2_pm_next;
    logic signed [49:0] s2_pr_next;

    assign s2_pm_next = s1_dm_reg * $signed({1'b0, s1_reg.new_age});
    assign s2_pr_next = s1_dr_reg * $signed({1'b0, s1_reg.new_age});

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s2_reg    <= s1_reg;
            s2_pm_reg <= s2_pm_next;
            s2_pr_reg <= s2_pr_next;
        end
    end

    // stage 3: mass and radius
    pay_t s3_reg;
    pay_t s3_next;

    always_comb
    begin
        s3_next = s2_reg;
        if (s2_reg.status == ST_ALIVE)
        begin
            s3_next.mass   = sat32(50'(s2_reg.mass) + (s2_pm_reg >>> 14));
            s3_next.radius = sat32(50'(s2_reg.radius) + (s2_pr_reg >>> 14));
        end
        else
        begin
            s3_next.mass   = '0;
            s3_next.radius = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
            s3_reg <= s3_next;
    end

    // divider stages, record travels alongside
    pay_t               side_reg [DIV_LAT];
    logic signed [31:0] qx [NUM_FORCES];
    logic signed [31:0] qy [NUM_FORCES];

    always_ff @(posedge clk)
    begin
        if (en[4])
            side_reg[0] <= s3_reg;
        for (int j = 1; j < DIV_LAT; j++)
            if (en[4+j])
                side_reg[j] <= side_reg[j-1];
    end

    for (genvar i = 0; i < NUM_FORCES; i++)
    begin : g_div
        peu_div u_div_x
        (
            .clk       (clk),
            .en        (en[4 +: DIV_LAT]),
            .force_val (fx_reg[i]),
            .mass      (s3_reg.mass),
            .quo       (qx[i])
        );

        peu_div u_div_y
        (
            .clk       (clk),
            .en        (en[4 +: DIV_LAT]),
            .force_val (fy_reg[i]),
            .mass      (s3_reg.mass),
            .quo       (qy[i])
        );
    end

    // quotient times dt, then one velocity stage per slot
    pay_t               vp_reg  [NUM_FORCES+1];
    logic signed [48:0] qdx_reg [NUM_FORCES][NUM_FORCES];
    logic signed [48:0] qdy_reg [NUM_FORCES][NUM_FORCES];

    always_ff @(posedge clk)
    begin
        if (en[S_Q])
            vp_reg[0] <= side_reg[DIV_LAT-1];
    end

    for (genvar i = 0; i < NUM_FORCES; i++)
    begin : g_qdt
        always_ff @(posedge clk)
        begin
            if (en[S_Q])
            begin
                qdx_reg[0][i] <= qx[i] * $signed({1'b0, dt});
                qdy_reg[0][i] <= qy[i] * $signed({1'b0, dt});
            end
        end
    end

    for (genvar s = 0; s < NUM_FORCES; s++)
    begin : g_vel
        pay_t vel_next;

        always_comb
        begin
            vel_next = vp_reg[s];
            if (vp_reg[s].status == ST_ALIVE && mask_reg[s])
            begin
                vel_next.vel_x = sat32(50'(vp_reg[s].vel_x) + 50'(qdx_reg[s][s] >>> 16));
                vel_next.vel_y = sat32(50'(vp_reg[s].vel_y) + 50'(qdy_reg[s][s] >>> 16));
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[S_Q+1+s])
                vp_reg[s+1] <= vel_next;
        end

        if (s + 1 < NUM_FORCES)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en[S_Q+1+s])
                begin
                    qdx_reg[s+1] <= qdx_reg[s];
                    qdy_reg[s+1] <= qdy_reg[s];
                end
            end
        end
    end

    // velocity times dt
    pay_t               vm_reg;
    logic signed [48:0] vdx_reg;
    logic signed [48:0] vdy_reg;

    always_ff @(posedge clk)
    begin
        if (en[S_VM])
        begin
            vm_reg  <= vp_reg[NUM_FORCES];
            vdx_reg <= vp_reg[NUM_FORCES].vel_x * $signed({1'b0, dt});
            vdy_reg <= vp_reg[NUM_FORCES].vel_y * $signed({1'b0, dt});
        end
    end

    // position, output register
    out_t out_reg;
    out_t out_next;

    always_comb
    begin
        out_next.status     = vm_reg.status;
        out_next.new_age    = vm_reg.new_age;
        out_next.mass_now   = vm_reg.mass;
        out_next.radius_now = vm_reg.radius;
        out_next.new_vel_x  = vm_reg.vel_x;
        out_next.new_vel_y  = vm_reg.vel_y;
        out_next.new_pos_x  = vm_reg.pos_x;
        out_next.new_pos_y  = vm_reg.pos_y;
        if (vm_reg.status == ST_ALIVE)
        begin
            out_next.new_pos_x = sat32(50'(vm_reg.pos_x) + 50'(vdx_reg >>> 16));
            out_next.new_pos_y = sat32(50'(vm_reg.pos_y) - 50'(vdy_reg >>> 16));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[S_P])
            out_reg <= out_next;
    end

    assign out_data = out_reg;

`ifndef SYNTHESIS
    a_dead_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_ALIVE
        |-> out_data.mass_now == '0 && out_data.radius_now == '0)
        else $error("mass/radius nonzero for non-alive particle");

    a_dead_age: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == ST_DEAD_BEFORE || out_data.status == ST_DIED_NOW)
        |-> out_data.new_age > AGE_ONE)
        else $error("dead status with age not above one");

    a_alive_age: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_ALIVE |-> out_data.new_age <= AGE_ONE)
        else $error("alive status with age above one");

    a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[0] |-> !in_stall)
        else $error("input stalled with empty first stage");
`endif

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Streams particle requests through particle_euler_update_top under several
// register settings, with random gaps and stalls on both sides. A scoreboard
// class predicts each record after one time step and checks results in order.
// ----------------------------------------------------------------------------
module tb_top;
    import peu_pkg::*;

    localparam longint S32_HI = 64'sd2147483647;
    localparam longint S32_LO = -64'sd2147483648;
    localparam int     DRAIN_CYCLES = 60;
    localparam int     CYCLE_LIMIT  = 600000;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    class particle_scoreboard;
        bit      paused;
        longint  time_step;
        bit [1:0] force_mask;
        longint  force_x[2];
        longint  force_y[2];
        out_t    expected_q[$];
        int      mismatches;

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_PAUSED:         paused = val[0];
                REG_TIME_STEP:      time_step = longint'(val[15:0]);
                REG_FORCE_MASK:     force_mask = val[1:0];
                REG_FORCE_X_FIRST:  force_x[0] = longint'(signed'(val));
                REG_FORCE_Y_FIRST:  force_y[0] = longint'(signed'(val));
                REG_FORCE_X_SECOND: force_x[1] = longint'(signed'(val));
                REG_FORCE_Y_SECOND: force_y[1] = longint'(signed'(val));
                default: ;
            endcase
        endfunction

        function longint clip32(longint v);
            if (v > S32_HI)
                return S32_HI;
            if (v < S32_LO)
                return S32_LO;
            return v;
        endfunction

        function longint lerp_by_age(longint b, longint d, longint a);
            return clip32(b + (((d - b) * a) >>> 14));
        endfunction

        function longint accel(longint f, longint m);
            if (m == 0)
            begin
                if (f > 0)
                    return S32_HI;
                if (f < 0)
                    return S32_LO;
                return 0;
            end
            return clip32((f * 65536) / m);
        endfunction

        function out_t step_particle(in_t p);
            out_t   o;
            longint dt, na, m, vx, vy, px, py;
            o = '0;
            dt = paused ? 0 : time_step;
            vx = longint'(p.vel_x);
            vy = longint'(p.vel_y);
            px = longint'(p.pos_x);
            py = longint'(p.pos_y);
            if (p.age > AGE_ONE)
            begin
                o.status = ST_DEAD_BEFORE;
                na = longint'(p.age);
            end
            else
            begin
                na = longint'(p.age) + ((dt * longint'(p.aging_rate)) >> 10);
                if (na > 65535)
                    na = 65535;
                if (na > longint'(AGE_ONE))
                    o.status = ST_DIED_NOW;
                else
                begin
                    o.status = ST_ALIVE;
                    m = lerp_by_age(longint'(p.mass_birth), longint'(p.mass_death), na);
                    for (int i = 0; i < 2; i++)
                    begin
                        if (force_mask[i])
                        begin
                            vx = clip32(vx + ((accel(force_x[i], m) * dt) >>> 16));
                            vy = clip32(vy + ((accel(force_y[i], m) * dt) >>> 16));
                        end
                    end
                    px = clip32(px + ((vx * dt) >>> 16));
                    py = clip32(py - ((vy * dt) >>> 16));
                    o.mass_now = m[31:0];
                    o.radius_now = lerp_by_age(longint'(p.radius_birth),
                                               longint'(p.radius_death), na);
                end
            end
            o.new_age = na[15:0];
            o.new_vel_x = vx[31:0];
            o.new_vel_y = vy[31:0];
            o.new_pos_x = px[31:0];
            o.new_pos_y = py[31:0];
            return o;
        endfunction

        function void note_request(in_t p);
            expected_q.insert(expected_q.size(), step_particle(p));
        endfunction

        function void report(string what, logic [31:0] e, logic [31:0] a);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %h actual %h", what, e, a);
        endfunction

        function void field(string what, logic [31:0] e, logic [31:0] a);
            if (e !== a)
                report(what, e, a);
        endfunction

        function void check_result(out_t r);
            out_t e;
            if (expected_q.size() == 0)
            begin
                report("unexpected result", 0, r.new_pos_x);
                return;
            end
            e = expected_q.pop_front();
            field("status", e.status, r.status);
            field("new_age", e.new_age, r.new_age);
            field("mass_now", e.mass_now, r.mass_now);
            field("new_vel_x", e.new_vel_x, r.new_vel_x);
            field("new_vel_y", e.new_vel_y, r.new_vel_y);
            field("new_pos_x", e.new_pos_x, r.new_pos_x);
            field("new_pos_y", e.new_pos_y, r.new_pos_y);
            field("radius_now", e.radius_now, r.radius_now);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_t         in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_t        out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    particle_scoreboard sb = new();
    int  cycles = 0;
    bit  no_idle = 0;
    bit  hold_req = 0;

    particle_euler_update_top u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
    end

    function int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // receiver: random stalls, with one long hold-off on request
    initial
    begin
        int n;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (200) @(negedge clk);
                hold_req = 0;
            end
            n = pick_gap();
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n - 1) @(negedge clk);
            end
            else
                out_stall <= 1'b0;
        end
    end

    function logic [31:0] rand_word();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return ($urandom_range(0, 1)) ? 32'h0 : 32'hffffffff;
            3, 4, 5, 6: return $urandom_range(0, 1) ? $urandom_range(0, 1 << 20)
                                               : -$urandom_range(0, 1 << 20);
            default: return $urandom;
        endcase
    endfunction

    function logic [31:0] rand_mass();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'h0;
        if (r < 6)
            return $urandom_range(1, 1 << 19);
        return rand_word();
    endfunction

    function in_t rand_particle();
        in_t p;
        int  r;
        r = $urandom_range(0, 9);
        if (r < 7)
            p.age = 16'($urandom_range(0, 16384));
        else if (r == 7)
            p.age = $urandom_range(0, 1) ? AGE_ONE : 16'd0;
        else
            p.age = 16'($urandom);
        p.aging_rate = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, 600));
        p.mass_birth = rand_mass();
        p.mass_death = rand_mass();
        p.vel_x = rand_word();
        p.vel_y = rand_word();
        p.pos_x = rand_word();
        p.pos_y = rand_word();
        p.radius_birth = rand_word();
        p.radius_death = rand_word();
        return p;
    endfunction

    task automatic send_request(in_t p);
        int n;
        @(negedge clk);
        in_valid <= 1'b1;
        in_data <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(p);
        n = pick_gap();
        if (n > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        in_valid <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_all(bit pz, logic [15:0] dt, logic [1:0] mask,
                           logic [31:0] fx0, logic [31:0] fy0,
                           logic [31:0] fx1, logic [31:0] fy1);
        write_reg(REG_PAUSED, {31'd0, pz});
        write_reg(REG_TIME_STEP, {16'd0, dt});
        write_reg(REG_FORCE_MASK, {30'd0, mask});
        write_reg(REG_FORCE_X_FIRST, fx0);
        write_reg(REG_FORCE_Y_FIRST, fy0);
        write_reg(REG_FORCE_X_SECOND, fx1);
        write_reg(REG_FORCE_Y_SECOND, fy1);
    endtask

    task automatic run_random(int n);
        repeat (n) send_request(rand_particle());
    endtask

    task automatic run_directed();
        in_t p;
        for (int k = 0; k < 20; k++)
        begin
            p = rand_particle();
            p.age = 16'd100;
            p.aging_rate = 16'd1;
            case (k)
                0: p.age = 16'd0;
                1: p.age = AGE_ONE;
                2: p.age = AGE_ONE + 16'd1;
                3: p.age = 16'hffff;
                4: p.aging_rate = 16'hffff;
                5: p.aging_rate = 16'd0;
                6: begin p.mass_birth = 0; p.mass_death = 0; end
                7: begin p.mass_birth = 32'h7fffffff; p.mass_death = 32'h7fffffff; end
                8: begin p.mass_birth = 32'h80000000; p.mass_death = 32'h7fffffff; end
                9: begin p.mass_birth = 32'h00000001; p.mass_death = 32'h00000001; end
                10: begin p.vel_x = 32'h7fffffff; p.pos_x = 32'h7fffffff; end
                11: begin p.vel_x = 32'h80000000; p.pos_x = 32'h80000000; end
                12: begin p.vel_y = 32'h7fffffff; p.pos_y = 32'h80000000; end
                13: begin p.vel_y = 32'h80000000; p.pos_y = 32'h7fffffff; end
                14: begin p.radius_birth = 32'h80000000; p.radius_death = 32'h7fffffff; end
                15: begin p.radius_birth = 32'h7fffffff; p.radius_death = 32'h80000000; end
                16: begin p.age = AGE_ONE; p.mass_birth = 32'h80000000; p.mass_death = 0; end
                17: begin p.mass_birth = -32'sd65536; p.mass_death = -32'sd65536; end
                18: begin p.age = 16'd16000; p.aging_rate = 16'd2000; end
                default: p.age = 16'd8192;
            endcase
            send_request(p);
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_random(40);
        drain();

        set_all(1'b0, 16'hffff, 2'b11, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
        run_directed();
        run_random(140);
        drain();

        set_all(1'b0, 16'd655, 2'b11, 32'h00010000, 32'hfffe0000, 32'h00008000, 32'h00030000);
        run_directed();
        hold_req = 1;
        run_random(160);
        drain();

        set_all(1'b1, 16'd40000, 2'b11, $urandom, $urandom, $urandom, $urandom);
        run_random(100);
        drain();

        no_idle = 1;
        set_all(1'b0, 16'd1, 2'b10, 32'h0, 32'h0, 32'hffff0000, 32'h00000100);
        run_random(120);
        drain();
        no_idle = 0;

        set_all(1'b0, 16'($urandom), 2'b01, rand_word(), rand_word(), rand_word(), rand_word());
        write_reg(REG_UNUSED, $urandom);
        run_random(140);
        drain();

        set_all(1'b0, 16'd3000, 2'b00, 32'h0, 32'h0, 32'h0, 32'h0);
        run_random(100);
        drain();

        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// ===== files.f =====
src/peu_pkg.sv
src/peu_div.sv
src/particle_euler_update_top.sv
tb/tb_top.sv
